// ===== sv/hfc_pkg.sv =====
// Package: shared constants and conversion functions for the half/single converter.
package hfc_pkg;

  localparam int unsigned OperandW = 32;
  localparam int unsigned ResultW  = 32;

  typedef enum logic {
    FUNC_H2S = 1'b0,
    FUNC_S2H = 1'b1
  } func_t;

  localparam logic [15:0] HalfMaxFin   = 16'h7BFF;
  localparam logic [7:0]  ExpBiasDiff  = 8'd112;
  localparam logic [7:0]  ExpOvfLimit  = 8'd143;
  localparam logic [7:0]  SubExpBase   = 8'd103;

  // Half to single, exact.
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic       sign;
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] p;
    logic [22:0] frac;
    logic [31:0] r;
    sign = h[15];
    ex   = h[14:10];
    man  = h[9:0];
    p    = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) p = 4'(i);
    end
    frac = 23'({man, 13'd0} << (4'd10 - p));
    if (ex == 5'd0) begin
      if (man == 10'd0) r = {sign, 31'd0};
      else r = {sign, SubExpBase + {4'd0, p}, frac};
    end else if (ex == 5'd31) begin
      r = {sign, 8'hFF, man, 13'd0};
    end else begin
      r = {sign, {3'd0, ex} + ExpBiasDiff, man, 13'd0};
    end
    return r;
  endfunction

  // Single to half, truncating, saturating, flushing.
  function automatic logic [31:0] narrow_single(input logic [31:0] s);
    logic       sign;
    logic [7:0] ex8;
    logic [7:0] hex;
    logic [15:0] h;
    sign = s[31];
    ex8  = s[30:23];
    hex  = ex8 - ExpBiasDiff;
    if (ex8 >= ExpOvfLimit) h = {sign, HalfMaxFin[14:0]};
    else if (ex8 <= ExpBiasDiff) h = {sign, 15'd0};
    else h = {sign, hex[4:0], s[22:13]};
    return {16'd0, h};
  endfunction

endpackage

// ===== sv/hfc_if.sv =====
// Interfaces: input and result channels.
interface hfc_in_if import hfc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [OperandW-1:0] operand;
  modport source (output valid, func, operand, input ready);
  modport sink   (input valid, func, operand, output ready);
endinterface

interface hfc_out_if import hfc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ResultW-1:0] result;
  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

// ===== sv/half_float_converter_unit.sv =====
// Top level: half/single bit-pattern converter, one item per cycle while out is not stalled.
//
//  channel | dir | payload              | handshake
//  in_ch   | in  | func, operand[31:0]  | valid/ready
//  out_ch  | out | result[31:0]         | valid/ready
//
// Pipeline: the operand is captured in the input reg and its conversion in the
// result reg; one item per cycle sustained while out is not stalled, set by the
// two-stage register pipe (input reg, result reg).
// Reset (sync, active low) clears the stage valid bits only.
// Stalls: each stage advances when the stage after it is empty or moving,
// so ready drops only when both stages hold items and out is stalled.
module half_float_converter_unit import hfc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  hfc_in_if.sink     in_ch,
  hfc_out_if.source  out_ch
);

  logic                s1_vld_r;
  logic                s1_func_r;
  logic [OperandW-1:0] s1_op_r;
  logic                s2_vld_r;
  logic [ResultW-1:0]  s2_res_r;
  logic                s2_adv;
  logic                s1_adv;
  logic [ResultW-1:0]  res_nxt;

  // result stage moves when empty or drained this cycle
  assign s2_adv = !s2_vld_r || out_ch.ready;
  assign s1_adv = !s1_vld_r || s2_adv;
  assign in_ch.ready = s1_adv;

  // conversion between the two registers
  always_comb begin
    if (func_t'(s1_func_r) == FUNC_S2H) res_nxt = narrow_single(s1_op_r);
    else res_nxt = widen_half(s1_op_r[15:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_adv) s1_vld_r <= in_ch.valid;
      if (s2_adv) s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_ch.valid) begin
      s1_func_r <= in_ch.func;
      s1_op_r   <= in_ch.operand;
    end
    if (s2_adv && s1_vld_r) s2_res_r <= res_nxt;
  end

  assign out_ch.valid  = s2_vld_r;
  assign out_ch.result = s2_res_r;

endmodule

// ===== sv/hfc_checker.sv =====
// Checker: port-level properties of the converter, bound to the top level.
module hfc_props import hfc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [ResultW-1:0] out_result
);
  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("result changed under stall");
  // no input handshake in either antecedent step and an empty output: nothing can appear next
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready) ##1 (!out_valid && !(in_valid && in_ready)) |=> !out_valid)
    else $error("result invented");
  // ready is high whenever output is free
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
  // an accepted item that moved on reaches the output
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_valid && in_ready, 2) && $past(in_ready) && out_ready |-> out_valid)
    else $error("item lost");
endmodule

bind half_float_converter_unit hfc_props u_hfc_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_result (out_ch.result)
);

// ===== dv/hfc_checker.sv =====
// Checker: watches both channels, predicts converted patterns and compares them.
module hfc_checker import hfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  hfc_in_if.sink    in_ch,
  hfc_out_if.sink   out_ch,
  output int        fail_count,
  output int        pending
);

  logic [31:0] expected_results[$];

  // Half to single, exact; subnormals normalized via leading-one position.
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  hexp;
    logic [9:0]  hman;
    int          lead;
    sgn  = {h[15], 31'd0};
    hexp = h[14:10];
    hman = h[9:0];
    lead = 0;
    if (hexp == 5'd0) begin
      if (hman == 10'd0) return sgn;
      for (int i = 0; i < 10; i++) if (hman[i]) lead = i;
      return sgn | (32'(lead + 103) << 23) | ((32'(hman) << (23 - lead)) & 32'h7FFFFF);
    end
    if (hexp == 5'd31) return sgn | 32'h7F800000 | (32'(hman) << 13);
    return sgn | ((32'(hexp) + 32'd112) << 23) | (32'(hman) << 13);
  endfunction

  // Single to half: truncate, saturate to max finite, flush to signed zero.
  function automatic logic [31:0] single_to_half(input logic [31:0] s);
    logic [31:0] sgn;
    logic [7:0]  sexp;
    sgn  = {16'd0, s[31], 15'd0};
    sexp = s[30:23];
    if (sexp >= 8'd143) return sgn | 32'h7BFF;
    if (sexp <= 8'd112) return sgn;
    return sgn | (32'(sexp - 8'd112) << 10) | 32'(s[22:13]);
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (func_t'(in_ch.func) == FUNC_H2S)
          expected_results.push_back(half_to_single(in_ch.operand[15:0]));
        else
          expected_results.push_back(single_to_half(in_ch.operand));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", out_ch.result);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== out_ch.result) begin
            if (fail_count < 10)
              $display("result mismatch: expected %h actual %h", want, out_ch.result);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top: drives operands, stalls the result side and reports the verdict.
module tb_top;
  import hfc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;

  always #5 clk = ~clk;

  hfc_in_if  in_ch ();
  hfc_out_if out_ch ();

  half_float_converter_unit dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  hfc_checker chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                   .fail_count(fail_count), .pending(pending));

  // Idle rates in percent; stall_hold forces a long receiver hold-off.
  int  send_idle = 37;
  int  recv_idle = 83;
  bit  stall_hold = 1'b0;
  int  idle_cycles = 0;
  localparam int WatchdogLimit = 5000;

  // Receiver: random ready, held low during a forced hold-off.
  always @(posedge clk) begin
    out_ch.ready <= !stall_hold && ($urandom_range(99) >= recv_idle);
  end

  // Watchdog: cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst_n && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
      idle_cycles <= idle_cycles + 1;
    else
      idle_cycles <= 0;
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL half_float_converter_unit");
      $finish;
    end
  end

  // Present one item, with random idle cycles ahead, and hold until accepted.
  task automatic send_item(input func_t fn, input logic [31:0] opnd);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= fn;
    in_ch.operand <= opnd;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Random operand biased toward interesting exponents.
  function automatic logic [31:0] pick_operand(input func_t fn);
    logic [31:0] v;
    v = $urandom;
    if (fn == FUNC_H2S) begin
      case ($urandom_range(3))
        0: v[14:10] = 5'd0;
        1: v[14:10] = 5'd31;
        default: ;
      endcase
    end else begin
      case ($urandom_range(5))
        0: v[30:23] = 8'd112 + 8'($urandom_range(1)) - 8'd0;
        1: v[30:23] = 8'd142 + 8'($urandom_range(1));
        2: v[30:23] = 8'($urandom_range(113, 142));
        3: v[30:23] = 8'($urandom_range(1)) * 8'hFF;
        default: ;
      endcase
    end
    return v;
  endfunction

  initial begin
    logic [31:0] directed_h2s[$];
    logic [31:0] directed_s2h[$];
    func_t fn;
    in_ch.valid   <= 1'b0;
    in_ch.func    <= 1'b0;
    in_ch.operand <= '0;
    directed_h2s = '{32'h0000_0000, 32'h0000_8000, 32'hFFFF_0001, 32'h0000_03FF,
                     32'h0000_8200, 32'h0000_0400, 32'h0000_7BFF, 32'h0000_7C00,
                     32'h0000_FC00, 32'h0000_7E01, 32'hFFFF_FFFF, 32'h0000_3C00};
    directed_s2h = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h3880_0000,
                     32'h3800_0000, 32'hB87F_FFFF, 32'h477F_E000, 32'h4780_0000,
                     32'hC77F_FFFF, 32'h7F80_0000, 32'hFFC0_0001, 32'h3F80_0000,
                     32'hFFFF_FFFF};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zeros, subnormals, extremes, infinities, NaNs, overflow, underflow.
    foreach (directed_h2s[i]) send_item(FUNC_H2S, directed_h2s[i]);
    foreach (directed_s2h[i]) send_item(FUNC_S2H, directed_s2h[i]);

    // Random, three idling phases.
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle = 83;
        recv_idle = 37;
      end else if (phase == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int n = 0; n < 600; n++) begin
        fn = func_t'($urandom_range(1));
        if (phase == 2 && n == 100) begin
          // Long receiver hold-off while items keep coming: pipe fills, input stalls.
          stall_hold <= 1'b1;
          fork
            begin
              repeat (40) @(posedge clk);
              stall_hold <= 1'b0;
            end
          join_none
        end
        send_item(fn, pick_operand(fn));
      end
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0)
      $display("PASS half_float_converter_unit");
    else
      $display("FAIL half_float_converter_unit");
    $finish;
  end

endmodule
